// ===== hdl/sacrr_pkg.sv =====
package sacrr_pkg;

    localparam int NUM_WAYS   = 8;     // power of two
    localparam int NUM_SETS   = 64;    // power of two
    localparam int ADDR_BITS  = 16;    // at most the address field width

    localparam int ADDR_W     = 16;
    localparam int WORD_W     = 32;
    localparam int SEED_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int USED_W     = 3;
    localparam int LINE_SHIFT = 4;

    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int TAG_W  = ADDR_BITS - LINE_SHIFT - SET_W;
    localparam int LINE_W = 4 * WORD_W;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [SEED_W-1:0] SEED_MIN  = 16'h0001;

    typedef enum logic [0:0] {
        CMD_LOOKUP = 1'b0,
        CMD_FILL   = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        RS_HIT     = 3'd0,
        RS_PENDING = 3'd1,
        RS_MISS    = 3'd2,
        RS_FILLED  = 3'd3,
        RS_NOMATCH = 3'd4
    } t_rsp_status;

    typedef enum logic [1:0] {
        WS_INVALID = 2'd0,
        WS_VALID   = 2'd1,
        WS_PENDING = 2'd2
    } t_way_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] fill_word0;
        logic [WORD_W-1:0] fill_word1;
        logic [WORD_W-1:0] fill_word2;
        logic [WORD_W-1:0] fill_word3;
    } t_req;

    typedef struct packed {
        t_rsp_status       status;
        logic [USED_W-1:0] way_used;
        logic [WORD_W-1:0] line_word0;
        logic [WORD_W-1:0] line_word1;
        logic [WORD_W-1:0] line_word2;
        logic [WORD_W-1:0] line_word3;
    } t_rsp;

    typedef struct packed {
        t_way_state       st;
        logic [TAG_W-1:0] tag;
    } t_meta;

    typedef t_meta [NUM_WAYS-1:0] t_meta_row;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch request, read tag row
        logic eval;     // compare, update, register result
        logic deliver;  // load hit line into result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic need_data;  // lookup hit on a valid way, line read under way
    } t_dp_sts;

endpackage

// ===== hdl/sacrr_ctrl.sv =====
module sacrr_ctrl
    import sacrr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_ctl    o_ctl,
    output logic    o_busy,
    output logic    o_rsp_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DATA
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.need_data) begin
                    n_state = S_DATA;
                end else begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            S_DATA: begin
                n_state     = S_IDLE;
                n_rsp_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_ctl.accept  = i_start && (r_state == S_IDLE);
    assign o_ctl.eval    = (r_state == S_LOOKUP);
    assign o_ctl.deliver = (r_state == S_DATA);
    assign o_busy        = (r_state != S_IDLE);
    assign o_rsp_valid   = r_rsp_valid;

endmodule

// ===== hdl/sacrr_dp.sv =====
module sacrr_dp
    import sacrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [SEED_W-1:0] i_cfg_data,
    output t_dp_sts           o_sts,
    output t_rsp              o_rsp
);

    // tag/state rows, one per set; a set never written reads as all invalid
    t_meta_row          mem_meta [NUM_SETS];
    logic [LINE_W-1:0]  mem_data [NUM_SETS*NUM_WAYS];

    logic [NUM_SETS-1:0] r_set_vld;
    logic [SEED_W-1:0]   r_lfsr;

    t_cmd              r_cmd;
    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;
    logic [LINE_W-1:0] r_fill;
    logic              r_row_vld;
    t_meta_row         r_meta_q;
    logic [LINE_W-1:0] r_data_q;
    t_rsp              r_rsp;

    logic [ADDR_BITS-LINE_SHIFT-1:0] in_line;
    logic [SET_W-1:0]  in_set;
    t_meta_row         row;
    logic              found;
    logic [WAY_W-1:0]  hit_w;
    logic              is_lookup;
    logic              hit_valid;
    logic              miss;
    logic              fill_hit;
    logic [WAY_W-1:0]  victim;
    logic [SEED_W-1:0] n_lfsr;
    t_meta_row         n_row;
    t_rsp              n_rsp;

    assign in_line = i_req.address[ADDR_BITS-1:LINE_SHIFT];
    assign in_set  = in_line[SET_W-1:0];

    assign row = r_row_vld ? r_meta_q : '0;

    // lowest matching way; a fill only matches pending ways
    always_comb begin
        found = 1'b0;
        hit_w = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && row[w].st != WS_INVALID && row[w].tag == r_tag &&
                (r_cmd == CMD_LOOKUP || row[w].st == WS_PENDING)) begin
                found = 1'b1;
                hit_w = WAY_W'(w);
            end
        end
    end

    assign is_lookup = (r_cmd == CMD_LOOKUP);
    assign hit_valid = is_lookup && found && (row[hit_w].st == WS_VALID);
    assign miss      = is_lookup && !found;
    assign fill_hit  = !is_lookup && found;
    assign victim    = r_lfsr[WAY_W-1:0];

    assign n_lfsr = {1'b0, r_lfsr[SEED_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);

    always_comb begin
        n_row = row;
        if (miss) begin
            n_row[victim].st  = WS_PENDING;
            n_row[victim].tag = r_tag;
        end else if (fill_hit) begin
            n_row[hit_w].st = WS_VALID;
        end
    end

    always_comb begin
        n_rsp = '0;
        if (is_lookup) begin
            if (!found) begin
                n_rsp.status   = RS_MISS;
                n_rsp.way_used = USED_W'(victim);
            end else begin
                n_rsp.status   = hit_valid ? RS_HIT : RS_PENDING;
                n_rsp.way_used = USED_W'(hit_w);
            end
        end else if (found) begin
            n_rsp.status     = RS_FILLED;
            n_rsp.way_used   = USED_W'(hit_w);
            n_rsp.line_word0 = r_fill[WORD_W-1:0];
            n_rsp.line_word1 = r_fill[2*WORD_W-1:WORD_W];
            n_rsp.line_word2 = r_fill[3*WORD_W-1:2*WORD_W];
            n_rsp.line_word3 = r_fill[4*WORD_W-1:3*WORD_W];
        end else begin
            n_rsp.status = RS_NOMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_vld <= '0;
            r_lfsr    <= SEED_MIN;
        end else begin
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_data == '0) ? SEED_MIN : i_cfg_data;
            end else if (i_ctl.eval && miss) begin
                r_lfsr <= n_lfsr;
            end
            if (i_ctl.eval && (miss || fill_hit)) begin
                r_set_vld[r_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd     <= i_req.cmd;
            r_set     <= in_set;
            r_tag     <= in_line[ADDR_BITS-LINE_SHIFT-1:SET_W];
            r_fill    <= {i_req.fill_word3, i_req.fill_word2,
                          i_req.fill_word1, i_req.fill_word0};
            r_row_vld <= r_set_vld[in_set];
        end
        if (i_ctl.eval) begin
            r_rsp <= n_rsp;
        end else if (i_ctl.deliver) begin
            r_rsp.line_word0 <= r_data_q[WORD_W-1:0];
            r_rsp.line_word1 <= r_data_q[2*WORD_W-1:WORD_W];
            r_rsp.line_word2 <= r_data_q[3*WORD_W-1:2*WORD_W];
            r_rsp.line_word3 <= r_data_q[4*WORD_W-1:3*WORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_meta_q <= mem_meta[in_set];
        end
        if (i_ctl.eval && (miss || fill_hit)) begin
            mem_meta[r_set] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval && fill_hit) begin
            mem_data[{r_set, hit_w}] <= r_fill;
        end
        if (i_ctl.eval && hit_valid) begin
            r_data_q <= mem_data[{r_set, hit_w}];
        end
    end

    assign o_sts.need_data = i_ctl.eval && hit_valid;
    assign o_rsp           = r_rsp;

endmodule

// ===== hdl/set_assoc_cache_random_replace_core.sv =====
// 8-way, 64-set cache tag/data core with 16-byte lines and random (LFSR)
// replacement. Pulse start while busy is low to issue a lookup or a fill
// request; exactly one response follows, shown for a single cycle with
// o_rsp_valid high, and it cannot be stalled. Miss, pending, fill and
// unmatched-fill responses follow a read of the set's tag row and a compare
// and write-back in the lookup state. Busy stays high until the response
// is shown, so a new request is taken only after the last one is done. A hit
// also passes the data state, which loads the line read from the data RAM. The
// valid state is kept per set in flip-flops, so the core is usable right
// out of reset with no clearing pass. Writing the seed (0 is taken as 1)
// restarts the victim LFSR; write it only while busy is low.
module set_assoc_cache_random_replace_core
    import sacrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    output t_rsp              o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SEED_W-1:0] i_cfg_data
);

    t_ctl    ctl;
    t_dp_sts sts;

    sacrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_busy      (busy),
        .o_rsp_valid (o_rsp_valid)
    );

    sacrr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_rsp      (o_rsp)
    );

    assign o_cfg_ready = !busy;

endmodule

// ===== hdl/sacrr_checker.sv =====
module sacrr_checker
    import sacrr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_rsp_valid,
    input t_rsp              o_rsp
);

    // a taken request always occupies the core for its compare cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but core not busy");

    // every response comes from a request that was in flight
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(busy))
        else $error("response without a request in flight");

    a_rsp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid)
        else $error("back-to-back responses");

    a_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == RS_MISS || o_rsp.status == RS_PENDING ||
                        o_rsp.status == RS_NOMATCH)
        |-> (o_rsp.line_word0 == '0) && (o_rsp.line_word1 == '0) &&
            (o_rsp.line_word2 == '0) && (o_rsp.line_word3 == '0))
        else $error("line data on a response that carries none");

    a_nomatch_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == RS_NOMATCH |-> o_rsp.way_used == '0)
        else $error("unmatched fill reports a way");

endmodule

bind set_assoc_cache_random_replace_core sacrr_checker u_sacrr_checker (.*);

// ===== bench/tb_set_assoc_cache_random_replace_core.sv =====
module tb_set_assoc_cache_random_replace_core
    import sacrr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES        = 4;
    localparam int PHASE_REQS    = 310;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RECENT_DEPTH  = 16;

    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_dir_row;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    t_req              req       = '0;
    logic              rsp_valid;
    t_rsp              rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SEED_W-1:0] cfg_data  = '0;

    // typed-in expectation travels with the request it belongs to
    bit                req_fixed     = 1'b0;
    t_rsp              req_fixed_rsp = '0;

    // cache mirror
    t_way_state        line_state [NUM_SETS][NUM_WAYS];
    logic [TAG_W-1:0]  line_tag   [NUM_SETS][NUM_WAYS];
    logic [WORD_W-1:0] line_data  [NUM_SETS][NUM_WAYS][4];
    logic [SEED_W-1:0] victim_sr;

    t_rsp              predicted_rsp_q [$];
    t_dir_row          dir_rows [$];
    logic [ADDR_W-1:0] recent_lines [$];
    logic [SET_W-1:0]  hot_sets [3];
    logic [TAG_W-1:0]  tag_base;

    int reqs_sent    = 0;
    int rsp_seen     = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int seeds_loaded = 0;
    int n_hit = 0, n_pend = 0, n_miss = 0, n_fill = 0, n_nomatch = 0;

    set_assoc_cache_random_replace_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void cache_reset();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                line_state[s][w] = WS_INVALID;
                line_tag[s][w]   = '0;
                for (int k = 0; k < 4; k++) line_data[s][w][k] = '0;
            end
        end
        victim_sr = SEED_MIN;
    endfunction

    function automatic t_rsp cache_predict(input t_req r);
        logic [SET_W-1:0] set_i;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] victim;
        int               way;
        t_rsp             o;
        set_i = r.address[LINE_SHIFT +: SET_W];
        tag   = r.address[LINE_SHIFT + SET_W +: TAG_W];
        o     = '0;
        way   = -1;
        // lowest matching way wins; a fill only matches pending ways
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (line_state[set_i][w] != WS_INVALID && line_tag[set_i][w] == tag &&
                (r.cmd == CMD_LOOKUP || line_state[set_i][w] == WS_PENDING))
                way = w;
        end
        if (r.cmd == CMD_LOOKUP) begin
            if (way >= 0) begin
                o.way_used = USED_W'(way);
                if (line_state[set_i][way] == WS_VALID) begin
                    o.status     = RS_HIT;
                    o.line_word0 = line_data[set_i][way][0];
                    o.line_word1 = line_data[set_i][way][1];
                    o.line_word2 = line_data[set_i][way][2];
                    o.line_word3 = line_data[set_i][way][3];
                end else begin
                    o.status = RS_PENDING;
                end
            end else begin
                victim    = victim_sr[WAY_W-1:0];
                victim_sr = {1'b0, victim_sr[SEED_W-1:1]} ^ (victim_sr[0] ? LFSR_TAPS : '0);
                line_state[set_i][victim] = WS_PENDING;
                line_tag[set_i][victim]   = tag;
                o.status   = RS_MISS;
                o.way_used = USED_W'(victim);
            end
        end else if (way >= 0) begin
            line_state[set_i][way]   = WS_VALID;
            line_data[set_i][way][0] = r.fill_word0;
            line_data[set_i][way][1] = r.fill_word1;
            line_data[set_i][way][2] = r.fill_word2;
            line_data[set_i][way][3] = r.fill_word3;
            o.status     = RS_FILLED;
            o.way_used   = USED_W'(way);
            o.line_word0 = r.fill_word0;
            o.line_word1 = r.fill_word1;
            o.line_word2 = r.fill_word2;
            o.line_word3 = r.fill_word3;
        end else begin
            o.status = RS_NOMATCH;
        end
        return o;
    endfunction

    task automatic check_field(input string fname, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        t_rsp want;
        t_rsp pred;
        if (rst_n) begin
            quiet_cycles++;
            if (rsp_valid) begin
                quiet_cycles = 0;
                rsp_seen++;
                if (predicted_rsp_q.size() == 0) begin
                    $display("%0t ns: response with none expected, got 0x%0h", $time, rsp);
                    mismatches++;
                end else begin
                    want = predicted_rsp_q.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
                    check_field("way_used", WORD_W'(want.way_used), WORD_W'(rsp.way_used));
                    check_field("line_word0", want.line_word0, rsp.line_word0);
                    check_field("line_word1", want.line_word1, rsp.line_word1);
                    check_field("line_word2", want.line_word2, rsp.line_word2);
                    check_field("line_word3", want.line_word3, rsp.line_word3);
                end
            end
            if (start && !busy) begin
                quiet_cycles = 0;
                pred = cache_predict(req);
                if (req_fixed) pred = req_fixed_rsp;
                predicted_rsp_q.insert(predicted_rsp_q.size(), pred);
                case (pred.status)
                    RS_HIT:     n_hit++;
                    RS_PENDING: n_pend++;
                    RS_MISS:    n_miss++;
                    RS_FILLED:  n_fill++;
                    default:    n_nomatch++;
                endcase
            end
            if (cfg_valid && cfg_ready) begin
                quiet_cycles = 0;
                victim_sr = (cfg_data == '0) ? SEED_MIN : cfg_data;
                seeds_loaded++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: timeout, no handshake for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic t_rsp mk_rsp(input t_rsp_status st, input int way,
                                     input logic [LINE_W-1:0] words);
        return t_rsp'({st, USED_W'(way), words});
    endfunction

    function automatic void add_row(input t_cmd c, input logic [ADDR_W-1:0] a,
                                    input logic [LINE_W-1:0] words, input bit fixed,
                                    input t_rsp r);
        t_dir_row row;
        row.req   = t_req'({c, a, words});
        row.fixed = fixed;
        row.rsp   = r;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly lookups into a few hot sets, fills of recently looked-up lines, and a few fully random requests
    function automatic t_req rand_req();
        t_req            r;
        int              pick;
        logic [3:0]      offs;
        logic [TAG_W-1:0] tag;
        r.fill_word0 = rand_word();
        r.fill_word1 = rand_word();
        r.fill_word2 = rand_word();
        r.fill_word3 = rand_word();
        r.cmd        = CMD_LOOKUP;
        offs         = 4'($urandom_range(0, 15));
        pick         = $urandom_range(0, 99);
        if (pick < 8) begin
            r.cmd     = t_cmd'($urandom_range(0, 1));
            r.address = ADDR_W'($urandom);
        end else if (pick < 45 && recent_lines.size() > 0) begin
            r.cmd     = CMD_FILL;
            r.address = recent_lines[$urandom_range(0, recent_lines.size() - 1)];
            r.address[3:0] = offs;
        end else begin
            tag       = tag_base + TAG_W'($urandom_range(0, 11));
            r.address = {tag, hot_sets[$urandom_range(0, 2)], offs};
            recent_lines.insert(recent_lines.size(), r.address);
            if (recent_lines.size() > RECENT_DEPTH) void'(recent_lines.pop_front());
        end
        return r;
    endfunction

    task automatic send_req(input t_req r, input bit fixed, input t_rsp fx, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        req           <= r;
        req_fixed     <= fixed;
        req_fixed_rsp <= fx;
        do @(posedge clk); while (busy);
        reqs_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (rsp_seen < reqs_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_seed(input logic [SEED_W-1:0] s);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [SEED_W-1:0] seeds [PHASES];
        logic [LINE_W-1:0] pat;
        int                gap;
        int                burst_left;
        cache_reset();
        pat = {32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF, 32'h00000000};

        // seed 0 is taken as 1: victims go 1, 0, 0, ...
        add_row(CMD_LOOKUP, 16'h0000, '0, 1'b1, mk_rsp(RS_MISS, 1, '0));
        add_row(CMD_LOOKUP, 16'h0003, '0, 1'b1, mk_rsp(RS_PENDING, 1, '0));
        add_row(CMD_FILL,   16'h0000, pat, 1'b1, mk_rsp(RS_FILLED, 1, pat));
        add_row(CMD_LOOKUP, 16'h000F, '1, 1'b1, mk_rsp(RS_HIT, 1, pat));
        add_row(CMD_FILL,   16'h0000, '1, 1'b1, mk_rsp(RS_NOMATCH, 0, '0));
        add_row(CMD_LOOKUP, 16'hFFFF, '0, 1'b1, mk_rsp(RS_MISS, 0, '0));
        add_row(CMD_FILL,   16'hFFF0, '1, 1'b1, mk_rsp(RS_FILLED, 0, '1));
        add_row(CMD_LOOKUP, 16'hFFFF, '0, 1'b1, mk_rsp(RS_HIT, 0, '1));
        add_row(CMD_FILL,   16'h1230, pat, 1'b1, mk_rsp(RS_NOMATCH, 0, '0));
        add_row(CMD_LOOKUP, 16'hFC00, '0, 1'b1, mk_rsp(RS_MISS, 0, '0));
        add_row(CMD_FILL,   16'hFC05, '0, 1'b0, '0);
        // crowd set 0 so victims land on valid and pending ways
        for (int t = 1; t <= 9; t++)
            add_row(CMD_LOOKUP, ADDR_W'(t << 10), '0, 1'b0, '0);
        add_row(CMD_LOOKUP, 16'h0000, '0, 1'b0, '0);
        add_row(CMD_FILL,   16'h03F0, '1, 1'b0, '0);
        add_row(CMD_FILL,   16'h1400, {4{32'hAAAA5555}}, 1'b0, '0);
        add_row(CMD_LOOKUP, 16'h1408, '0, 1'b0, '0);

        seeds[0] = 16'hFFFF;
        seeds[1] = 16'h8000;
        seeds[2] = SEED_W'($urandom_range(1, 65535));
        seeds[3] = SEED_MIN;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        load_seed('0);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp, $urandom_range(0, 2));

        burst_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_seed(seeds[p]);
            tag_base = TAG_W'($urandom);
            foreach (hot_sets[h]) hot_sets[h] = SET_W'($urandom);
            recent_lines.delete();
            for (int i = 0; i < PHASE_REQS; i++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    gap = 0;
                end
                burst_left--;
                send_req(rand_req(), 1'b0, '0, gap);
            end
        end

        settle();
        $display("Ran %0d requests (%0d directed) under %0d seed loads.",
                 reqs_sent, dir_rows.size(), seeds_loaded);
        $display("Responses: %0d hit, %0d pending, %0d miss, %0d filled, %0d unmatched fill.",
                 n_hit, n_pend, n_miss, n_fill, n_nomatch);
        if (mismatches == 0 && predicted_rsp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
